// ===== sv/stfc_pkg.sv =====
`timescale 1ns / 1ps

package stfc_pkg;

	// Table size: slot 0 is never used, so there is one cell for each of slots 1 to BAY_COUNT-1.
	localparam int BAY_COUNT = 16;
	localparam int CELLS     = BAY_COUNT - 1;
	localparam int CNT_W     = $clog2(CELLS + 1);

	// Fixed field widths.
	localparam int CMD_W     = 2;
	localparam int PAYLOAD_W = 32;
	localparam int SLOT_W    = 4;
	localparam int STATUS_W  = 3;
	localparam int SLOT_LIM  = 1 << SLOT_W;

	// Command codes. The unused code answers as an invalid request.
	typedef enum logic [CMD_W-1:0] {
		CMD_STORE       = 2'd0,
		CMD_RETRIEVE    = 2'd1,
		CMD_CONSOLIDATE = 2'd2
	} stfc_cmd_e;

	// Status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_STORED       = 3'd0,
		STAT_NO_ROOM      = 3'd1,
		STAT_RETRIEVED    = 3'd2,
		STAT_INVALID      = 3'd3,
		STAT_CONSOLIDATED = 3'd4
	} stfc_status_e;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} stfc_state_e;

	// Request payload.
	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [PAYLOAD_W-1:0] payload_in;
		logic [SLOT_W-1:0]    slot_number;
	} stfc_req_t;

	// Response payload.
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot_out;
		logic [PAYLOAD_W-1:0] payload_out;
		logic                 payload_valid;
	} stfc_rsp_t;

	// Controls broadcast to every cell.
	typedef struct packed {
		logic store_en;
		logic retr_en;
		logic shift_en;
	} stfc_ctl_t;

	// What the cell row reports back to the controller.
	typedef struct packed {
		logic                 any_free;
		logic [SLOT_W-1:0]    claim_slot;
		logic                 hit_occ;
		logic [PAYLOAD_W-1:0] hit_payload;
	} stfc_look_t;

endpackage

// ===== sv/stfc_cell.sv =====
`timescale 1ns / 1ps

module stfc_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stfc_pkg::stfc_ctl_t            ctl,
	input  logic [stfc_pkg::PAYLOAD_W-1:0] store_data,
	input  logic                           hit,
	input  logic                           empty_below,
	input  logic                           up_occ,
	input  logic [stfc_pkg::PAYLOAD_W-1:0] up_payload,
	output logic                           empty_out,
	output logic                           claim,
	output logic                           occ,
	output logic [stfc_pkg::PAYLOAD_W-1:0] payload
);

	logic                           occ_q;
	logic [stfc_pkg::PAYLOAD_W-1:0] payload_q;
	logic                           take;

	// The lowest empty cell claims a store; every cell at or above the lowest hole
	// takes its upper neighbor during a compaction step.
	assign empty_out = empty_below | ~occ_q;
	assign claim     = ~occ_q & ~empty_below;
	assign take      = empty_out;
	assign occ       = occ_q;
	assign payload   = payload_q;

	// Occupied mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.shift_en && take) begin
			occ_q <= up_occ;
		end else if (ctl.store_en && claim) begin
			occ_q <= 1'b1;
		end else if (ctl.retr_en && hit) begin
			occ_q <= 1'b0;
		end
	end

	// Payload word.
	always_ff @(posedge clk) begin
		if (ctl.shift_en && take) begin
			payload_q <= up_payload;
		end else if (ctl.store_en && claim) begin
			payload_q <= store_data;
		end
	end

endmodule

// ===== sv/stfc_ctrl.sv =====
`timescale 1ns / 1ps

module stfc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  stfc_pkg::stfc_req_t   req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output stfc_pkg::stfc_rsp_t   rsp_data,
	output stfc_pkg::stfc_req_t   req_held,
	output stfc_pkg::stfc_ctl_t   ctl,
	input  stfc_pkg::stfc_look_t  look
);

	stfc_pkg::stfc_state_e         state_q;
	stfc_pkg::stfc_state_e         state_d;
	stfc_pkg::stfc_req_t           req_q;
	stfc_pkg::stfc_rsp_t           rsp_q;
	stfc_pkg::stfc_rsp_t           rsp_d;
	logic                          rsp_valid_q;
	logic [stfc_pkg::CNT_W-1:0]    cnt_q;
	logic                          rsp_free;
	logic                          compact_run;
	logic                          fire;
	logic                          is_store;
	logic                          is_retr;
	logic                          is_cons;

	assign is_store    = req_q.command == stfc_pkg::CMD_STORE;
	assign is_retr     = req_q.command == stfc_pkg::CMD_RETRIEVE;
	assign is_cons     = req_q.command == stfc_pkg::CMD_CONSOLIDATE;
	assign rsp_free    = ~rsp_valid_q | rsp_ready;
	assign compact_run = (state_q == stfc_pkg::S_EXEC) && is_cons
		&& (cnt_q != stfc_pkg::CNT_W'(stfc_pkg::CELLS));
	assign fire        = (state_q == stfc_pkg::S_EXEC) && !compact_run && rsp_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			stfc_pkg::S_IDLE: begin
				if (req_valid) state_d = stfc_pkg::S_EXEC;
			end
			stfc_pkg::S_EXEC: begin
				if (fire) state_d = stfc_pkg::S_IDLE;
			end
			default: state_d = stfc_pkg::S_IDLE;
		endcase
	end

	// Outputs toward the channels and the cell row.
	always_comb begin
		req_ready    = state_q == stfc_pkg::S_IDLE;
		ctl.shift_en = compact_run;
		ctl.store_en = fire && is_store;
		ctl.retr_en  = fire && is_retr;
	end

	// Response word for the held request.
	always_comb begin
		rsp_d = '0;
		case (req_q.command)
			stfc_pkg::CMD_STORE: begin
				if (look.any_free) begin
					rsp_d.status   = stfc_pkg::STAT_STORED;
					rsp_d.slot_out = look.claim_slot;
				end else begin
					rsp_d.status = stfc_pkg::STAT_NO_ROOM;
				end
			end
			stfc_pkg::CMD_RETRIEVE: begin
				if (look.hit_occ) begin
					rsp_d.status        = stfc_pkg::STAT_RETRIEVED;
					rsp_d.payload_out   = look.hit_payload;
					rsp_d.payload_valid = 1'b1;
				end else begin
					rsp_d.status = stfc_pkg::STAT_INVALID;
				end
			end
			stfc_pkg::CMD_CONSOLIDATE: begin
				rsp_d.status = stfc_pkg::STAT_CONSOLIDATED;
			end
			default: begin
				rsp_d.status = stfc_pkg::STAT_INVALID;
			end
		endcase
	end

	// Control registers: state, compaction step count, response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stfc_pkg::S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				cnt_q <= '0;
			end else if (compact_run) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Held request and response payload.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req_data;
		if (fire) rsp_q <= rsp_d;
	end

	assign req_held  = req_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	// An accepted request always moves the controller into execution.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == stfc_pkg::S_EXEC)
		else $error("accepted request did not start execution");

	// A compaction step never coincides with a store or retrieve update.
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_en |-> !(ctl.store_en || ctl.retr_en))
		else $error("compaction step overlaps a table update");

	// The step counter never runs past the cell count.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= stfc_pkg::CNT_W'(stfc_pkg::CELLS))
		else $error("compaction counter out of range");

	// A new response appears only when execution finishes.
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q ##1 rsp_valid_q |-> $past(state_q == stfc_pkg::S_EXEC))
		else $error("response raised outside execution");

	// A compacted table answers only after all steps have run.
	a_cons_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_cons |-> cnt_q == stfc_pkg::CNT_W'(stfc_pkg::CELLS))
		else $error("consolidate answered before compaction finished");
`endif

endmodule

// ===== sv/slot_table_first_fit_compact.sv =====
`timescale 1ns / 1ps

// Slot table with first-fit store, retrieve by slot number and order-keeping compaction.
// A request (command, payload_in, slot_number) enters on req_valid/req_ready; one
// response (status, slot_out, payload_out, payload_valid) leaves on rsp_valid/rsp_ready
// for every request. The table is a row of BAY_COUNT-1 cells, one per slot from 1 up.
// Store and retrieve search the row in the execute state; once the response register is
// free, the cells update and the response is registered, raising rsp_valid, and the
// controller goes back to idle to accept the next request. Consolidate first shifts every
// cell above the lowest hole down by one neighbor per cycle for BAY_COUNT-1 steps and then
// answers, once the response register is free; that step count sets the worst case.
// One request is in work at a time; req_ready is high while the controller is idle.
// The response register holds a finished response while the receiver stalls, and the
// next request is accepted meanwhile; it finishes once that register is free.
// Reset clears every occupied mark, the controller and the response valid; payload
// words are not cleared and are only read from occupied slots.
module slot_table_first_fit_compact (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  stfc_pkg::stfc_req_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output stfc_pkg::stfc_rsp_t rsp_data
);

	stfc_pkg::stfc_req_t           req_held;
	stfc_pkg::stfc_ctl_t           ctl;
	stfc_pkg::stfc_look_t          look;
	logic [stfc_pkg::CELLS:0]      empty_chain;
	logic [stfc_pkg::CELLS:0]      occ_up;
	logic [stfc_pkg::PAYLOAD_W-1:0] pay_up [stfc_pkg::CELLS+1];
	logic [stfc_pkg::CELLS-1:0]    claim;
	logic [stfc_pkg::CELLS-1:0]    hit;
	logic [stfc_pkg::CELLS-1:0]    occ;
	logic [stfc_pkg::PAYLOAD_W-1:0] payload [stfc_pkg::CELLS];

	// Controller: handshakes, sequencing and response formatting.
	stfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.req_held  (req_held),
		.ctl       (ctl),
		.look      (look)
	);

	// Ends of the chain: nothing empty below slot 1, nothing above the top cell.
	assign empty_chain[0]              = 1'b0;
	assign occ_up[stfc_pkg::CELLS]     = 1'b0;
	assign pay_up[stfc_pkg::CELLS]     = '0;

	// Row of cells; cell k holds slot k+1 and hands its contents down to cell k-1.
	for (genvar k = 0; k < stfc_pkg::CELLS; k++) begin : g_cell
		assign hit[k] = ((k + 1) < stfc_pkg::SLOT_LIM)
			&& (req_held.slot_number == stfc_pkg::SLOT_W'(k + 1));
		assign occ_up[k] = occ[k];
		assign pay_up[k] = payload[k];

		stfc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.store_data  (req_held.payload_in),
			.hit         (hit[k]),
			.empty_below (empty_chain[k]),
			.up_occ      (occ_up[k+1]),
			.up_payload  (pay_up[k+1]),
			.empty_out   (empty_chain[k+1]),
			.claim       (claim[k]),
			.occ         (occ[k]),
			.payload     (payload[k])
		);
	end

	// Collect the claiming slot number and the addressed payload from the row.
	always_comb begin
		look.any_free    = empty_chain[stfc_pkg::CELLS];
		look.claim_slot  = '0;
		look.hit_occ     = 1'b0;
		look.hit_payload = '0;
		for (int k = 0; k < stfc_pkg::CELLS; k++) begin
			if (claim[k]) look.claim_slot = look.claim_slot | stfc_pkg::SLOT_W'(k + 1);
			if (hit[k] && occ[k]) begin
				look.hit_occ     = 1'b1;
				look.hit_payload = look.hit_payload | payload[k];
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// Run limits.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 60;
	localparam int RANDOM_ITEMS = 1400;

	// Tracks the slot table and checks every response against the oldest expected one.
	class slot_scoreboard;
		logic [stfc_pkg::PAYLOAD_W-1:0] cell_word [stfc_pkg::BAY_COUNT];
		bit                             cell_busy [stfc_pkg::BAY_COUNT];
		stfc_pkg::stfc_rsp_t            awaited [$];
		int                             mismatches;

		function new();
			mismatches = 0;
			for (int i = 0; i < stfc_pkg::BAY_COUNT; i++) begin
				cell_word[i] = '0;
				cell_busy[i] = 1'b0;
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= PRINT_LIMIT) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int busy_count();
			int n;
			n = 0;
			for (int i = 1; i < stfc_pkg::BAY_COUNT; i++) begin
				if (cell_busy[i]) n++;
			end
			return n;
		endfunction

		// Picks one occupied slot at random, or 0 when the table is empty.
		function int pick_busy_slot();
			int list [$];
			for (int i = 1; i < stfc_pkg::BAY_COUNT && i < stfc_pkg::SLOT_LIM; i++) begin
				if (cell_busy[i]) list.push_back(i);
			end
			if (list.size() == 0) return 0;
			return list[$urandom_range(list.size() - 1)];
		endfunction

		// Applies an accepted request to the table copy and queues its response.
		function void note(stfc_pkg::stfc_req_t r);
			stfc_pkg::stfc_rsp_t exp;
			int                  wr;
			bit                  placed;
			exp = '0;
			case (r.command)
				stfc_pkg::CMD_STORE: begin
					placed = 1'b0;
					for (int i = 1; i < stfc_pkg::BAY_COUNT && !placed; i++) begin
						if (!cell_busy[i]) begin
							cell_busy[i] = 1'b1;
							cell_word[i] = r.payload_in;
							exp.status   = stfc_pkg::STAT_STORED;
							exp.slot_out = i[stfc_pkg::SLOT_W-1:0];
							placed       = 1'b1;
						end
					end
					if (!placed) exp.status = stfc_pkg::STAT_NO_ROOM;
				end
				stfc_pkg::CMD_RETRIEVE: begin
					if (r.slot_number == 0 || int'(r.slot_number) >= stfc_pkg::BAY_COUNT ||
							!cell_busy[r.slot_number]) begin
						exp.status = stfc_pkg::STAT_INVALID;
					end else begin
						cell_busy[r.slot_number] = 1'b0;
						exp.status        = stfc_pkg::STAT_RETRIEVED;
						exp.payload_out   = cell_word[r.slot_number];
						exp.payload_valid = 1'b1;
					end
				end
				stfc_pkg::CMD_CONSOLIDATE: begin
					// Occupied slots slide down in order toward slot 1.
					wr = 1;
					for (int rd = 1; rd < stfc_pkg::BAY_COUNT; rd++) begin
						if (cell_busy[rd]) begin
							if (rd != wr) begin
								cell_word[wr] = cell_word[rd];
								cell_busy[wr] = 1'b1;
								cell_busy[rd] = 1'b0;
							end
							wr++;
						end
					end
					exp.status = stfc_pkg::STAT_CONSOLIDATED;
				end
				default: begin
					exp.status = stfc_pkg::STAT_INVALID;
				end
			endcase
			awaited.push_back(exp);
		endfunction

		function void check(stfc_pkg::stfc_rsp_t got);
			stfc_pkg::stfc_rsp_t exp;
			if (awaited.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			exp = awaited.pop_front();
			if (got.status !== exp.status)
				report($sformatf("status %0d, expected %0d", got.status, exp.status));
			if (got.slot_out !== exp.slot_out)
				report($sformatf("slot_out %0d, expected %0d", got.slot_out, exp.slot_out));
			if (got.payload_out !== exp.payload_out)
				report($sformatf("payload_out %h, expected %h",
					got.payload_out, exp.payload_out));
			if (got.payload_valid !== exp.payload_valid)
				report($sformatf("payload_valid %b, expected %b",
					got.payload_valid, exp.payload_valid));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	stfc_pkg::stfc_req_t req_data;
	logic                rsp_valid;
	logic                rsp_ready;
	stfc_pkg::stfc_rsp_t rsp_data;

	slot_scoreboard table_sb;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             cycles;

	slot_table_first_fit_compact dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The receiver stalls at random, once per cycle.
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watch both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) table_sb.note(req_data);
			if (rsp_valid && rsp_ready) table_sb.check(rsp_data);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Presents one request, idling first at random, and returns after it is accepted.
	task automatic send_req(input stfc_pkg::stfc_cmd_e cmd,
			input logic [stfc_pkg::PAYLOAD_W-1:0] word,
			input logic [stfc_pkg::SLOT_W-1:0] slot);
		stfc_pkg::stfc_req_t r;
		r.command     = cmd;
		r.payload_in  = word;
		r.slot_number = slot;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// Holds off new requests until every outstanding response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (table_sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [stfc_pkg::PAYLOAD_W-1:0] random_word();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return $urandom;
	endfunction

	// Mostly stores and retrieves of live slots, with stray slots, compaction and the
	// unused command mixed in.
	task automatic random_phase(input int n);
		int pick;
		int store_pct;
		for (int k = 0; k < n; k++) begin
			pick      = $urandom_range(99);
			store_pct = (table_sb.busy_count() > 10) ? 35 : 50;
			if (pick < store_pct) begin
				send_req(stfc_pkg::CMD_STORE, random_word(), stfc_pkg::SLOT_W'($urandom));
			end else if (pick < 82) begin
				send_req(stfc_pkg::CMD_RETRIEVE, random_word(),
					stfc_pkg::SLOT_W'(table_sb.pick_busy_slot()));
			end else if (pick < 90) begin
				send_req(stfc_pkg::CMD_RETRIEVE, random_word(),
					stfc_pkg::SLOT_W'($urandom_range(stfc_pkg::SLOT_LIM - 1)));
			end else if (pick < 97) begin
				send_req(stfc_pkg::CMD_CONSOLIDATE, random_word(),
					stfc_pkg::SLOT_W'($urandom));
			end else begin
				send_req(stfc_pkg::stfc_cmd_e'(2'd3), random_word(),
					stfc_pkg::SLOT_W'($urandom));
			end
		end
	endtask

	initial begin
		table_sb      = new();
		cycles        = 0;
		send_idle_pct = 17;
		recv_idle_pct = 66;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_data      = '0;
		rsp_ready     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: empty table, field extremes, a full table and the unused command.
		send_req(stfc_pkg::CMD_CONSOLIDATE, '0, '0);
		send_req(stfc_pkg::CMD_RETRIEVE, '1, 4'd3);
		send_req(stfc_pkg::CMD_STORE, '0, '0);
		send_req(stfc_pkg::CMD_STORE, '1, '1);
		for (int i = 0; i < stfc_pkg::BAY_COUNT - 3; i++)
			send_req(stfc_pkg::CMD_STORE, $urandom, 4'd0);
		send_req(stfc_pkg::CMD_STORE, 32'h5a5a_a5a5, 4'd9);
		send_req(stfc_pkg::CMD_RETRIEVE, '0, 4'd0);
		send_req(stfc_pkg::CMD_RETRIEVE, '0, 4'd15);
		send_req(stfc_pkg::CMD_RETRIEVE, '0, 4'd7);
		send_req(stfc_pkg::CMD_RETRIEVE, '0, 4'd7);
		send_req(stfc_pkg::CMD_CONSOLIDATE, '1, '1);
		send_req(stfc_pkg::stfc_cmd_e'(2'd3), '1, '1);
		drain();

		// Random part in three pacing phases.
		random_phase(RANDOM_ITEMS / 3);
		drain();
		send_idle_pct = 66;
		recv_idle_pct = 17;
		random_phase(RANDOM_ITEMS / 3);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		// Let the last responses arrive, then allow for a full compaction.
		drain();
		repeat (stfc_pkg::BAY_COUNT + 8) @(posedge clk);
		if (table_sb.pending() != 0) table_sb.report("responses still outstanding at end");
		if (table_sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
